>>> design/idw_pkg.sv
// Shared types and constants for the inverse-distance raster interpolator.
package idw_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_FRAC_BITS = 14;
    localparam int RECIP_FRAC_BITS = 16;
    localparam int MIN_POINTS      = 3;
    localparam int GRID_MIN        = 8;
    localparam int GRID_MAX        = 256;
    localparam int COORD_W         = 16;
    localparam int VALUE_W         = 32;
    localparam int IDX_W           = 8;
    localparam int GRID_W          = 9;
    localparam int POWER_W         = 3;
    localparam int SNAP_W          = 30;
    localparam int WEIGHT_W        = 32;
    localparam int D2_W            = 33;
    localparam int RAD_W           = 34;
    localparam int ROOT_W          = RAD_W / 2;
    localparam int MAG_W           = COORD_FRAC_BITS + 1;

    localparam logic [GRID_W-1:0]  GRID_RESET  = 9'd64;
    localparam logic [POWER_W-1:0] POWER_RESET = 3'd2;
    localparam logic [SNAP_W-1:0]  SNAP_RESET  = '0;

    typedef enum logic [1:0] {
        CFG_GRID_SIZE = 2'd0,
        CFG_POWER     = 2'd1,
        CFG_SNAP      = 2'd2
    } idw_cfg_t;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_RENDER = 2'd2
    } idw_cmd_t;

    typedef enum logic [3:0] {
        STAT_INTERP  = 4'd0,
        STAT_SNAP    = 4'd1,
        STAT_OUTSIDE = 4'd2,
        STAT_UNDEF   = 4'd3,
        STAT_FEW     = 4'd4,
        STAT_STORED  = 4'd5,
        STAT_IGNORED = 4'd6,
        STAT_FULL    = 4'd7,
        STAT_CLEARED = 4'd8
    } idw_status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_X_GO, S_X_WAIT, S_Y_GO, S_Y_WAIT, S_DSK1, S_DSK2, S_DSK3,
        S_PT_ADDR, S_PT_DIST, S_PT_SQ1, S_PT_SQ2, S_PT_SNAP, S_PT_SQRT,
        S_PT_RGO, S_PT_RWAIT, S_PT_POW, S_PT_POWW, S_PT_ACCH, S_PT_ACCL,
        S_FINAL, S_F_WAIT, S_EMIT
    } idw_state_t;

endpackage

>>> design/idw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module idw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/idw_div.sv
// Restoring unsigned divider, one quotient bit per cycle, variable step count.
module idw_div #(
    parameter int NUM_W = 71,
    parameter int DEN_W = 39
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    input  logic [$clog2(NUM_W+1)-1:0]   steps,
    output logic                         busy,
    output logic [NUM_W-1:0]             quo
);

    localparam int SW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [SW-1:0]    cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [SW-1:0]    shamt;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign shamt = SW'(NUM_W) - steps;
    assign busy  = busy_reg;
    assign quo   = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // numerator is left-aligned so only the live bits are walked
            q_reg   <= num << shamt;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

endmodule

>>> design/idw_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module idw_sqrt #(
    parameter int RAD_W = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 busy,
    output logic [RAD_W/2-1:0]   root
);

    localparam int HW = RAD_W / 2;
    localparam int CW = $clog2(HW + 1);

    logic [RAD_W-1:0] v_reg;
    logic [HW-1:0]    root_reg;
    logic [HW+1:0]    rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;

    logic [HW+3:0]    sh;
    logic [HW+3:0]    trial;
    logic [HW+3:0]    diff;
    logic             ge;

    assign sh    = {rem_reg, v_reg[RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = sh >= trial;
    assign diff  = sh - trial;
    assign busy  = busy_reg;
    assign root  = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(HW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[HW-2:0], ge};
            rem_reg  <= ge ? diff[HW+1:0] : sh[HW+1:0];
        end
    end

endmodule

>>> design/idw_disk_raster_interpolator_unit.sv
// Top level: point table, render sequencer, shared multiplier, divider and root units.
//
// One transaction on the item channel gives exactly one result. Clear and
// load go straight from idle to the emit state. A render first builds the
// pixel coordinate with two 22-step divisions and a disk test, then walks
// every stored point through the table RAM: distance squares on the shared
// multiplier, an iterative square root, a reciprocal division and one
// multiply per extra power step. The final weighted mean is a restoring
// division of 64 + clog2(MAX_POINTS+1) steps, started in S_FINAL and
// collected in S_F_WAIT. A snapped point ends the walk early. The iterative
// root and the shared divider set the per-point cost.
// One item is in work at a time; the next item is taken while a finished
// result still waits on the output.
module idw_disk_raster_interpolator_unit #(
    parameter int MAX_POINTS = idw_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [idw_pkg::SNAP_W-1:0]        cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        cmd,
    input  logic signed [idw_pkg::COORD_W-1:0] point_x,
    input  logic signed [idw_pkg::COORD_W-1:0] point_y,
    input  logic signed [idw_pkg::VALUE_W-1:0] point_value,
    input  logic                              point_usable,
    input  logic [idw_pkg::IDX_W-1:0]         column_index,
    input  logic [idw_pkg::IDX_W-1:0]         row_index,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [idw_pkg::VALUE_W-1:0] pixel_value,
    output logic [3:0]                        status
);

    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int ACC_W  = 48 + CW;
    localparam int NUM_W  = 64 + CW;
    localparam int DEN_W  = idw_pkg::WEIGHT_W + CW;
    localparam int SW     = $clog2(NUM_W + 1);
    localparam int ENT_W  = 2 * idw_pkg::COORD_W + idw_pkg::VALUE_W;
    localparam int F      = idw_pkg::COORD_FRAC_BITS;
    localparam int MAG_W  = idw_pkg::MAG_W;

    idw_pkg::idw_state_t state_reg, state_next;

    // configuration
    logic [idw_pkg::GRID_W-1:0]  grid_reg;
    logic [idw_pkg::POWER_W-1:0] power_reg;
    logic [idw_pkg::SNAP_W-1:0]  snap_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] k_reg;
    logic [idw_pkg::IDX_W-1:0] col_reg, row_reg, nm1_reg;
    logic          sx_reg, sy_reg;
    logic [MAG_W-1:0] ux_reg, uy_reg;
    logic [15:0]   adx_reg, ady_reg;
    logic [31:0]   val_reg;
    logic [idw_pkg::D2_W-1:0] d2_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   r_reg, w_reg;
    logic [2:0]    pw_reg, step_reg;
    logic [ACC_W-1:0] acc_h_reg, acc_l_reg;
    logic [DEN_W-1:0] den_reg;
    logic [31:0]   res_value_reg;
    idw_pkg::idw_status_t res_status_reg;
    logic          result_valid_reg;
    logic [31:0]   result_value_reg;
    logic [3:0]    result_status_reg;

    // handshakes
    logic item_accept;
    logic out_free;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != idw_pkg::S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign pixel_value  = result_value_reg;
    assign status       = result_status_reg;

    // grid clamp and idle decisions
    logic [idw_pkg::GRID_W-1:0] n_clamp;
    logic [idw_pkg::IDX_W-1:0]  nm1;
    logic                       render_ok;
    logic                       load_ok;
    idw_pkg::idw_status_t       idle_status;
    logic [2:0]                 p_clamp;

    always_comb
    begin
        if (grid_reg < idw_pkg::GRID_W'(idw_pkg::GRID_MIN))
            n_clamp = idw_pkg::GRID_W'(idw_pkg::GRID_MIN);
        else if (grid_reg > idw_pkg::GRID_W'(idw_pkg::GRID_MAX))
            n_clamp = idw_pkg::GRID_W'(idw_pkg::GRID_MAX);
        else
            n_clamp = grid_reg;
        nm1 = idw_pkg::IDX_W'(n_clamp - 1'b1);

        if (power_reg == 3'd0)
            p_clamp = 3'd1;
        else if (power_reg > 3'd4)
            p_clamp = 3'd4;
        else
            p_clamp = power_reg;

        load_ok   = point_usable && (count_reg < CW'(MAX_POINTS));
        render_ok = (count_reg >= CW'(idw_pkg::MIN_POINTS))
                    && ({1'b0, column_index} < n_clamp)
                    && ({1'b0, row_index} < n_clamp);

        case (cmd)
            idw_pkg::CMD_CLEAR:
                idle_status = idw_pkg::STAT_CLEARED;
            idw_pkg::CMD_LOAD:
                if (!point_usable)
                    idle_status = idw_pkg::STAT_IGNORED;
                else if (!load_ok)
                    idle_status = idw_pkg::STAT_FULL;
                else
                    idle_status = idw_pkg::STAT_STORED;
            idw_pkg::CMD_RENDER:
                if (count_reg < CW'(idw_pkg::MIN_POINTS))
                    idle_status = idw_pkg::STAT_FEW;
                else
                    idle_status = idw_pkg::STAT_OUTSIDE;
            default:
                idle_status = idw_pkg::STAT_IGNORED;
        endcase
    end

    // pixel numerators
    logic signed [9:0] numx, numy;
    logic [9:0]        numx_abs, numy_abs;

    assign numx     = $signed({1'b0, col_reg, 1'b0}) - $signed({2'b00, nm1_reg});
    assign numy     = $signed({2'b00, nm1_reg}) - $signed({1'b0, row_reg, 1'b0});
    assign numx_abs = numx[9] ? 10'(-numx) : numx;
    assign numy_abs = numy[9] ? 10'(-numy) : numy;

    // table RAM
    logic              ram_we, ram_re;
    logic [ENT_W-1:0]  ram_rdata;

    assign ram_we = item_accept && (cmd == idw_pkg::CMD_LOAD) && load_ok;
    assign ram_re = (state_reg == idw_pkg::S_PT_ADDR);

    idw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({point_x, point_y, point_value}),
        .re    (ram_re),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // point distance
    logic signed [16:0] xs, ys, dx, dy;
    logic [15:0]        rx16, ry16;
    logic [31:0]        rv;

    assign rx16 = ram_rdata[ENT_W-1 -: 16];
    assign ry16 = ram_rdata[ENT_W-17 -: 16];
    assign rv   = ram_rdata[31:0];
    assign xs   = sx_reg ? -$signed({2'b00, ux_reg}) : $signed({2'b00, ux_reg});
    assign ys   = sy_reg ? -$signed({2'b00, uy_reg}) : $signed({2'b00, uy_reg});
    assign dx   = xs - $signed({rx16[15], rx16});
    assign dy   = ys - $signed({ry16[15], ry16});

    logic [idw_pkg::D2_W-1:0] d2_sum;
    assign d2_sum = d2_reg + prod_reg[idw_pkg::D2_W-1:0];

    // divider and root
    logic             div_start, div_busy;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic [SW-1:0]    div_steps;
    logic             sq_start, sq_busy;
    logic [idw_pkg::ROOT_W-1:0] sq_root;

    idw_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    idw_sqrt #(
        .RAD_W (idw_pkg::RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({1'b0, d2_sum}),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [15:0] u_hi, u_lo;
    logic [31:0] w_sat;

    assign u_hi  = {~val_reg[31], val_reg[30:16]};
    assign u_lo  = val_reg[15:0];
    assign w_sat = (prod_reg[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod_reg[47:16];

    logic [NUM_W-1:0] mean_num;
    assign mean_num = {acc_h_reg, 16'd0} + NUM_W'(acc_l_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idw_pkg::S_IDLE:
                if (item_accept)
                    state_next = (cmd == idw_pkg::CMD_RENDER && render_ok)
                                 ? idw_pkg::S_X_GO : idw_pkg::S_EMIT;
            idw_pkg::S_X_GO:  state_next = idw_pkg::S_X_WAIT;
            idw_pkg::S_X_WAIT:
                if (!div_busy) state_next = idw_pkg::S_Y_GO;
            idw_pkg::S_Y_GO:  state_next = idw_pkg::S_Y_WAIT;
            idw_pkg::S_Y_WAIT:
                if (!div_busy) state_next = idw_pkg::S_DSK1;
            idw_pkg::S_DSK1:  state_next = idw_pkg::S_DSK2;
            idw_pkg::S_DSK2:  state_next = idw_pkg::S_DSK3;
            idw_pkg::S_DSK3:
                state_next = (d2_sum > idw_pkg::D2_W'(1 << (2 * F)))
                             ? idw_pkg::S_EMIT : idw_pkg::S_PT_ADDR;
            idw_pkg::S_PT_ADDR: state_next = idw_pkg::S_PT_DIST;
            idw_pkg::S_PT_DIST: state_next = idw_pkg::S_PT_SQ1;
            idw_pkg::S_PT_SQ1:  state_next = idw_pkg::S_PT_SQ2;
            idw_pkg::S_PT_SQ2:  state_next = idw_pkg::S_PT_SNAP;
            idw_pkg::S_PT_SNAP:
                state_next = (d2_sum <= idw_pkg::D2_W'(snap_reg))
                             ? idw_pkg::S_EMIT : idw_pkg::S_PT_SQRT;
            idw_pkg::S_PT_SQRT:
                if (!sq_busy) state_next = idw_pkg::S_PT_RGO;
            idw_pkg::S_PT_RGO:  state_next = idw_pkg::S_PT_RWAIT;
            idw_pkg::S_PT_RWAIT:
                if (!div_busy) state_next = idw_pkg::S_PT_POW;
            idw_pkg::S_PT_POW:
                state_next = (step_reg < pw_reg) ? idw_pkg::S_PT_POWW : idw_pkg::S_PT_ACCH;
            idw_pkg::S_PT_POWW: state_next = idw_pkg::S_PT_POW;
            idw_pkg::S_PT_ACCH: state_next = idw_pkg::S_PT_ACCL;
            idw_pkg::S_PT_ACCL:
                state_next = (k_reg + 1'b1 == count_reg) ? idw_pkg::S_FINAL
                                                         : idw_pkg::S_PT_ADDR;
            idw_pkg::S_FINAL:
                state_next = (den_reg == '0) ? idw_pkg::S_EMIT : idw_pkg::S_F_WAIT;
            idw_pkg::S_F_WAIT:
                if (!div_busy) state_next = idw_pkg::S_EMIT;
            idw_pkg::S_EMIT:
                if (out_free) state_next = idw_pkg::S_IDLE;
            default: state_next = idw_pkg::S_IDLE;
        endcase
    end

    // unit controls
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_steps = '0;
        sq_start  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            idw_pkg::S_X_GO:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({numx_abs[7:0], {F{1'b0}}});
                div_den   = DEN_W'(nm1_reg);
                div_steps = SW'(F + 8);
            end
            idw_pkg::S_Y_GO:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'({numy_abs[7:0], {F{1'b0}}});
                div_den   = DEN_W'(nm1_reg);
                div_steps = SW'(F + 8);
            end
            idw_pkg::S_DSK1:
            begin
                mul_a = 32'(ux_reg);
                mul_b = 32'(ux_reg);
            end
            idw_pkg::S_DSK2:
            begin
                mul_a = 32'(uy_reg);
                mul_b = 32'(uy_reg);
            end
            idw_pkg::S_PT_SQ1:
            begin
                mul_a = 32'(adx_reg);
                mul_b = 32'(adx_reg);
            end
            idw_pkg::S_PT_SQ2:
            begin
                mul_a = 32'(ady_reg);
                mul_b = 32'(ady_reg);
            end
            idw_pkg::S_PT_SNAP:
                sq_start = (d2_sum > idw_pkg::D2_W'(snap_reg));
            idw_pkg::S_PT_RGO:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(1) << (F + idw_pkg::RECIP_FRAC_BITS);
                div_den   = DEN_W'(sq_root);
                div_steps = SW'(F + idw_pkg::RECIP_FRAC_BITS + 1);
            end
            idw_pkg::S_PT_POW:
            begin
                mul_a = w_reg;
                mul_b = (step_reg < pw_reg) ? r_reg : 32'(u_hi);
            end
            idw_pkg::S_PT_ACCH:
            begin
                mul_a = w_reg;
                mul_b = 32'(u_lo);
            end
            idw_pkg::S_FINAL:
            begin
                div_start = (den_reg != '0);
                div_num   = mean_num;
                div_den   = den_reg;
                div_steps = SW'(NUM_W);
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= idw_pkg::S_IDLE;
            grid_reg         <= idw_pkg::GRID_RESET;
            power_reg        <= idw_pkg::POWER_RESET;
            snap_reg         <= idw_pkg::SNAP_RESET;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    idw_pkg::CFG_GRID_SIZE: grid_reg  <= cfg_data[idw_pkg::GRID_W-1:0];
                    idw_pkg::CFG_POWER:     power_reg <= cfg_data[idw_pkg::POWER_W-1:0];
                    idw_pkg::CFG_SNAP:      snap_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (item_accept && cmd == idw_pkg::CMD_CLEAR)
                count_reg <= '0;
            else if (ram_we)
                count_reg <= count_reg + 1'b1;
            if (state_reg == idw_pkg::S_EMIT && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            idw_pkg::S_IDLE:
                if (item_accept)
                begin
                    col_reg        <= column_index;
                    row_reg        <= row_index;
                    nm1_reg        <= nm1;
                    pw_reg         <= p_clamp;
                    k_reg          <= '0;
                    acc_h_reg      <= '0;
                    acc_l_reg      <= '0;
                    den_reg        <= '0;
                    res_value_reg  <= '0;
                    res_status_reg <= idle_status;
                end
            idw_pkg::S_X_GO:
                sx_reg <= numx[9];
            idw_pkg::S_X_WAIT:
                ux_reg <= div_quo[MAG_W-1:0];
            idw_pkg::S_Y_GO:
                sy_reg <= numy[9];
            idw_pkg::S_Y_WAIT:
                uy_reg <= div_quo[MAG_W-1:0];
            idw_pkg::S_DSK2:
                d2_reg <= prod_reg[idw_pkg::D2_W-1:0];
            idw_pkg::S_DSK3:
                res_status_reg <= idw_pkg::STAT_OUTSIDE;
            idw_pkg::S_PT_DIST:
            begin
                adx_reg <= dx[16] ? 16'(-dx) : dx[15:0];
                ady_reg <= dy[16] ? 16'(-dy) : dy[15:0];
                val_reg <= rv;
            end
            idw_pkg::S_PT_SQ2:
                d2_reg <= prod_reg[idw_pkg::D2_W-1:0];
            idw_pkg::S_PT_SNAP:
            begin
                res_value_reg  <= val_reg;
                res_status_reg <= idw_pkg::STAT_SNAP;
            end
            idw_pkg::S_PT_RWAIT:
            begin
                r_reg    <= div_quo[31:0];
                w_reg    <= div_quo[31:0];
                step_reg <= 3'd1;
            end
            idw_pkg::S_PT_POWW:
            begin
                w_reg    <= w_sat;
                step_reg <= step_reg + 1'b1;
            end
            idw_pkg::S_PT_ACCH:
                acc_h_reg <= acc_h_reg + ACC_W'(prod_reg[47:0]);
            idw_pkg::S_PT_ACCL:
            begin
                acc_l_reg <= acc_l_reg + ACC_W'(prod_reg[47:0]);
                den_reg   <= den_reg + DEN_W'(w_reg);
                k_reg     <= k_reg + 1'b1;
            end
            idw_pkg::S_FINAL:
            begin
                res_value_reg  <= '0;
                res_status_reg <= idw_pkg::STAT_UNDEF;
            end
            idw_pkg::S_F_WAIT:
            begin
                res_value_reg  <= div_quo[31:0] ^ 32'h8000_0000;
                res_status_reg <= idw_pkg::STAT_INTERP;
            end
            idw_pkg::S_EMIT:
                if (out_free)
                begin
                    result_value_reg  <= res_value_reg;
                    result_status_reg <= res_status_reg;
                end
            default:
            begin
            end
        endcase
    end

endmodule

>>> bench/idw_disk_raster_interpolator_unit_tb.sv
// Self-checking testbench for the inverse-distance raster interpolator: directed and random items.
module idw_disk_raster_interpolator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NPTS  = idw_pkg::MAX_POINTS_DEF;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [idw_pkg::VALUE_W-1:0] value;
        idw_pkg::idw_status_t        stat;
    } pixel_result_t;

    // Tracks the point table and configuration, and holds the pixel results still owed.
    class idw_raster_predictor;
        longint        grid_reg;
        longint        power_reg;
        longint        snap_reg;
        longint        px[NPTS];
        longint        py[NPTS];
        longint        pv[NPTS];
        int            npoints;
        int            errors;
        int            checked;
        pixel_result_t owed_pixels[$];

        function new();
            grid_reg  = longint'(idw_pkg::GRID_RESET);
            power_reg = longint'(idw_pkg::POWER_RESET);
            snap_reg  = longint'(idw_pkg::SNAP_RESET);
            npoints   = 0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(idw_pkg::idw_cfg_t idx, logic [idw_pkg::SNAP_W-1:0] data);
            case (idx)
                idw_pkg::CFG_GRID_SIZE: grid_reg  = longint'(data[idw_pkg::GRID_W-1:0]);
                idw_pkg::CFG_POWER:     power_reg = longint'(data[idw_pkg::POWER_W-1:0]);
                idw_pkg::CFG_SNAP:      snap_reg  = longint'(data);
                default: ;
            endcase
        endfunction

        function longint grid_n();
            if (grid_reg < idw_pkg::GRID_MIN) return longint'(idw_pkg::GRID_MIN);
            if (grid_reg > idw_pkg::GRID_MAX) return longint'(idw_pkg::GRID_MAX);
            return grid_reg;
        endfunction

        // Pixel center in Q2.14, quotient truncated toward zero.
        function longint pix_coord(longint num);
            longint den;
            longint q;
            den = grid_n() - 1;
            q = ((num < 0 ? -num : num) << idw_pkg::COORD_FRAC_BITS) / den;
            return num < 0 ? -q : q;
        endfunction

        function longint isqrt(longint v);
            longint r;
            longint b;
            r = 0;
            b = longint'(1) << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function pixel_result_t render(longint col, longint row);
            pixel_result_t res;
            longint n, p, x, y, dx, dy, d2, r, w, u, acc_h, acc_l, den, qh, rh, t, q;
            res.value = '0;
            if (npoints < idw_pkg::MIN_POINTS) begin
                res.stat = idw_pkg::STAT_FEW;
                return res;
            end
            n = grid_n();
            if (col >= n || row >= n) begin
                res.stat = idw_pkg::STAT_OUTSIDE;
                return res;
            end
            x = pix_coord(2 * col - (n - 1));
            y = pix_coord((n - 1) - 2 * row);
            if (x * x + y * y > (longint'(1) << (2 * idw_pkg::COORD_FRAC_BITS))) begin
                res.stat = idw_pkg::STAT_OUTSIDE;
                return res;
            end
            p = power_reg < 1 ? 1 : (power_reg > 4 ? 4 : power_reg);
            acc_h = 0;
            acc_l = 0;
            den   = 0;
            for (int k = 0; k < npoints; k++) begin
                dx = x - px[k];
                dy = y - py[k];
                d2 = dx * dx + dy * dy;
                if (d2 <= snap_reg) begin
                    res.value = pv[k][31:0];
                    res.stat  = idw_pkg::STAT_SNAP;
                    return res;
                end
                r = (longint'(1) << (idw_pkg::COORD_FRAC_BITS + idw_pkg::RECIP_FRAC_BITS))
                    / isqrt(d2);
                if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
                w = r;
                for (int s = 1; s < p; s++) begin
                    w = (w * r) >> idw_pkg::RECIP_FRAC_BITS;
                    if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
                end
                u = pv[k] ^ 64'h8000_0000;
                acc_h += w * (u >> 16);
                acc_l += w * (u & 64'hFFFF);
                den   += w;
            end
            if (den == 0) begin
                res.stat = idw_pkg::STAT_UNDEF;
                return res;
            end
            qh = acc_h / den;
            rh = acc_h % den;
            t  = (rh << 16) + acc_l;
            q  = (qh << 16) + t / den;
            res.value = q[31:0] ^ 32'h8000_0000;
            res.stat  = idw_pkg::STAT_INTERP;
            return res;
        endfunction

        function void note_item(logic [1:0] c, logic [15:0] x, logic [15:0] y,
                                logic [31:0] v, logic usable, logic [7:0] col,
                                logic [7:0] row);
            pixel_result_t res;
            res.value = '0;
            case (c)
                idw_pkg::CMD_CLEAR: begin
                    npoints  = 0;
                    res.stat = idw_pkg::STAT_CLEARED;
                end
                idw_pkg::CMD_LOAD: begin
                    if (!usable) begin
                        res.stat = idw_pkg::STAT_IGNORED;
                    end else if (npoints >= NPTS) begin
                        res.stat = idw_pkg::STAT_FULL;
                    end else begin
                        px[npoints] = longint'($signed(x));
                        py[npoints] = longint'($signed(y));
                        pv[npoints] = longint'(v);
                        npoints++;
                        res.stat = idw_pkg::STAT_STORED;
                    end
                end
                idw_pkg::CMD_RENDER: res = render(longint'(col), longint'(row));
                default: res.stat = idw_pkg::STAT_IGNORED;
            endcase
            owed_pixels.insert(owed_pixels.size(), res);
        endfunction

        function void check_pixel(logic [31:0] v, logic [3:0] st);
            pixel_result_t exp_res;
            if (owed_pixels.size() == 0) begin
                $error("result with nothing outstanding: pixel_value %0d status %0d",
                       $signed(v), st);
                errors++;
                return;
            end
            exp_res = owed_pixels.pop_front();
            checked++;
            if (st !== exp_res.stat) begin
                $error("status: expected %0d actual %0d", exp_res.stat, st);
                errors++;
            end
            if (v !== exp_res.value) begin
                $error("pixel_value: expected %0d actual %0d",
                       $signed(exp_res.value), $signed(v));
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [1:0]                  cfg_index;
    logic [idw_pkg::SNAP_W-1:0]  cfg_data;
    logic                        item_valid;
    logic                        item_stall;
    logic [1:0]                  cmd;
    logic signed [15:0]          point_x;
    logic signed [15:0]          point_y;
    logic signed [31:0]          point_value;
    logic                        point_usable;
    logic [7:0]                  column_index;
    logic [7:0]                  row_index;
    logic                        result_valid;
    logic                        result_stall;
    logic signed [31:0]          pixel_value;
    logic [3:0]                  status;

    idw_raster_predictor model = new();
    bit     idle_off;
    int     stall_left;
    int     stall_load;
    int     take_count;
    int     take_seen;
    int     renders_sent;
    longint cycles;

    idw_disk_raster_interpolator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_value  (point_value),
        .point_usable (point_usable),
        .column_index (column_index),
        .row_index    (row_index),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_value  (pixel_value),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("idw_disk_raster_interpolator_unit: mismatch");
            $finish;
        end
    end

    // Result side: stall count drawn per transaction.
    always @(negedge clk)
    begin
        if (take_count != take_seen) begin
            take_seen  = take_count;
            stall_left = stall_load;
        end
        if (stall_left > 0) begin
            result_stall <= 1'b1;
            stall_left--;
        end else begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) begin
            model.check_pixel(pixel_value, status);
            stall_load = idle_off ? 0 : $urandom_range(0, 16);
            take_count++;
        end
    end

    task automatic write_reg(idw_pkg::idw_cfg_t idx, logic [idw_pkg::SNAP_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        model.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic [1:0] c, logic [15:0] x, logic [15:0] y,
                             logic [31:0] v, logic usable, logic [7:0] col,
                             logic [7:0] row);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        cmd          <= c;
        point_x      <= x;
        point_y      <= y;
        point_value  <= v;
        point_usable <= usable;
        column_index <= col;
        row_index    <= row;
        do @(posedge clk); while (item_stall);
        model.note_item(c, x, y, v, usable, col, row);
        if (c == idw_pkg::CMD_RENDER) renders_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (model.owed_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic render_at(int col, int row);
        send_item(idw_pkg::CMD_RENDER, '0, '0, $urandom, 1'b0, col[7:0], row[7:0]);
    endtask

    // Load a point that sits exactly on a pixel center, so that pixel snaps.
    task automatic load_on_pixel(int col, int row, logic [31:0] v);
        longint n, x, y;
        n = model.grid_n();
        x = model.pix_coord(2 * col - (n - 1));
        y = model.pix_coord((n - 1) - 2 * row);
        send_item(idw_pkg::CMD_LOAD, x[15:0], y[15:0], v, 1'b1, '0, '0);
    endtask

    task automatic random_item(int cap);
        int     roll;
        int     n, col, row;
        logic [15:0] x, y;
        n    = int'(model.grid_n());
        roll = $urandom_range(0, 99);
        if (model.npoints >= cap && roll >= 3 && roll < 45) roll = 60;
        if (roll < 3) begin
            send_item(idw_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom), 8'($urandom), 8'($urandom));
        end else if (roll < 5) begin
            send_item(2'd3, 16'($urandom), 16'($urandom), $urandom, 1'($urandom),
                      8'($urandom), 8'($urandom));
        end else if (roll < 45) begin
            if ($urandom_range(0, 6) == 0) begin
                load_on_pixel($urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end else begin
                    x = 16'($signed($urandom_range(0, 32768)) - 16384);
                    y = 16'($signed($urandom_range(0, 32768)) - 16384);
                end
                send_item(idw_pkg::CMD_LOAD, x, y, $urandom, $urandom_range(0, 9) != 0,
                          8'($urandom), 8'($urandom));
            end
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                col = $urandom_range(0, 255);
                row = $urandom_range(0, 255);
            end else begin
                col = $urandom_range(0, n - 1);
                row = $urandom_range(0, n - 1);
            end
            send_item(idw_pkg::CMD_RENDER, 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom), col[7:0], row[7:0]);
        end
    endtask

    initial
    begin
        logic [idw_pkg::SNAP_W-1:0] grid_set[8];
        logic [idw_pkg::SNAP_W-1:0] power_set[8];
        logic [idw_pkg::SNAP_W-1:0] snap_set[8];
        int                         cap_set[8];

        grid_set  = '{30'd64, 30'd8, 30'd256, 30'd0, 30'd300, 30'd17, 30'd1000, 30'd0};
        power_set = '{30'd2, 30'd1, 30'd4, 30'd0, 30'd7, 30'd3, 30'd5, 30'd2};
        snap_set  = '{30'd0, 30'h3FFF_FFFF, 30'd1048576, 30'd0, 30'd16777216, 30'd0,
                      30'd1000, 30'd0};
        cap_set   = '{8, 6, 10, 70, 5, 12, 8, 4};
        grid_set[7]  = 30'($urandom_range(0, 511));
        power_set[7] = 30'($urandom_range(0, 7));
        snap_set[7]  = 30'($urandom_range(0, 1 << 22));

        renders_sent = 0;
        idle_off     = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = idw_pkg::CFG_GRID_SIZE;
        cfg_data     = '0;
        item_valid   = 1'b0;
        cmd          = idw_pkg::CMD_CLEAR;
        point_x      = '0;
        point_y      = '0;
        point_value  = '0;
        point_usable = 1'b0;
        column_index = '0;
        row_index    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset configuration, boundary fields, each status but STAT_FULL and STAT_UNDEF.
        render_at(32, 32);
        send_item(2'd3, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF);
        send_item(idw_pkg::CMD_LOAD, 16'h1234, 16'h4321, 32'd99, 1'b0, '0, '0);
        send_item(idw_pkg::CMD_LOAD, 16'h8000, 16'h7FFF, 32'h8000_0000, 1'b1, '0, '0);
        render_at(32, 32);
        send_item(idw_pkg::CMD_LOAD, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 1'b1, '0, '0);
        send_item(idw_pkg::CMD_LOAD, 16'h0000, 16'h0000, 32'd12345, 1'b1, '0, '0);
        render_at(0, 0);
        render_at(64, 3);
        render_at(3, 64);
        render_at(255, 255);
        render_at(32, 32);
        render_at(31, 0);
        render_at(63, 31);
        load_on_pixel(10, 31, 32'hDEAD_BEEF);
        render_at(10, 31);
        render_at(11, 31);
        send_item(idw_pkg::CMD_CLEAR, '0, '0, '0, 1'b0, '0, '0);
        render_at(10, 31);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(idw_pkg::CFG_GRID_SIZE, grid_set[ph]);
            write_reg(idw_pkg::CFG_POWER, power_set[ph]);
            write_reg(idw_pkg::CFG_SNAP, snap_set[ph]);
            idle_off = (ph == 2 || ph == 5);
            send_item(idw_pkg::CMD_CLEAR, '0, '0, '0, 1'b0, '0, '0);
            for (int k = 0; k < 125; k++) begin
                if (model.npoints >= cap_set[ph] && cap_set[ph] < NPTS &&
                    $urandom_range(0, 3) == 0)
                    send_item(idw_pkg::CMD_CLEAR, '0, '0, '0, 1'b0, '0, '0);
                else
                    random_item(cap_set[ph]);
            end
            // Let everything owed come back before the next register change.
            drain();
        end

        drain();
        $display("Covered %0d results (%0d renders) over 8 register settings,", model.checked,
                 renders_sent);
        $display("grid 8..256 with saturation, power 0..7, snap radius zero to maximum.");
        if (model.errors == 0 && model.owed_pixels.size() == 0) begin
            $display("idw_disk_raster_interpolator_unit: match");
        end else begin
            $display("idw_disk_raster_interpolator_unit: mismatch");
        end
        $finish;
    end

endmodule
